/* src/cns_pkg.sv */
package cns_pkg;

  localparam int GUIDE_W = 46;
  localparam int START_W = 32;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_G = 8'h47;
  localparam logic [7:0] CHAR_T = 8'h54;
  localparam logic [7:0] CASE_FOLD_MASK = 8'hDF;

  localparam logic [1:0] CODE_A = 2'd0;
  localparam logic [1:0] CODE_C = 2'd1;
  localparam logic [1:0] CODE_G = 2'd2;
  localparam logic [1:0] CODE_T = 2'd3;

  localparam logic [3:0] PAM_GG = {CODE_G, CODE_G};
  localparam logic [3:0] PAM_CC = {CODE_C, CODE_C};

  typedef struct packed {
    logic       valid;
    logic [1:0] code;
  } base_dec_t;

  typedef struct packed {
    logic fwd;
    logic rev;
  } match_t;

  function automatic base_dec_t decode_base(input logic [7:0] ch);
    base_dec_t  d;
    logic [7:0] up;
    up = ch & CASE_FOLD_MASK;
    d.valid = 1'b1;
    case (up)
      CHAR_A: d.code = CODE_A;
      CHAR_C: d.code = CODE_C;
      CHAR_G: d.code = CODE_G;
      CHAR_T: d.code = CODE_T;
      default: begin
        d.valid = 1'b0;
        d.code = CODE_A;
      end
    endcase
    return d;
  endfunction

endpackage

/* src/cns_front.sv */
module cns_front #(
  parameter int GUIDE_LEN = 23,
  parameter int POS_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   base_valid,
  output logic                                   base_ready,
  input  logic [7:0]                             base_char,
  input  logic                                   seq_start,
  input  logic                                   queue_full,
  output logic                                   push,
  output logic [2*GUIDE_LEN-1:0]                 push_window,
  output logic [cns_pkg::START_W-1:0]            push_start,
  output cns_pkg::match_t                        push_flags
);
  import cns_pkg::*;

  localparam int WIN_W = 2 * GUIDE_LEN;
  localparam int RUN_W = $clog2(GUIDE_LEN + 1);
  localparam logic [RUN_W-1:0] RUN_FULL = RUN_W'(GUIDE_LEN);
  localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};
  localparam logic [POS_WIDTH-1:0] START_OFS = POS_WIDTH'(GUIDE_LEN - 1);

  logic [WIN_W-1:0]     window, window_next, win_base;
  logic [RUN_W-1:0]     run, run_next, run_base;
  logic [POS_WIDTH-1:0] position, position_next, pos_base;
  logic [POS_WIDTH-1:0] start;
  base_dec_t            dec;
  logic                 accept;
  logic                 full;

  assign base_ready = !queue_full;
  assign accept = base_valid && base_ready;

  always_comb begin
    dec = decode_base(base_char);
    win_base = seq_start ? '0 : window;
    run_base = seq_start ? '0 : run;
    pos_base = seq_start ? '0 : position;
    position_next = (pos_base == POS_MAX) ? pos_base : pos_base + 1'b1;
    if (dec.valid) begin
      window_next = {win_base[WIN_W-3:0], dec.code};
      run_next = (run_base < RUN_FULL) ? run_base + 1'b1 : run_base;
    end else begin
      window_next = '0;
      run_next = '0;
    end
    full = dec.valid && (run_next == RUN_FULL);
    start = pos_base - START_OFS;
    push_flags.fwd = full && (window_next[3:0] == PAM_GG);
    push_flags.rev = full && (window_next[WIN_W-1 -: 4] == PAM_CC);
    push_window = window_next;
    push_start = START_W'(start);
    push = accept && (push_flags.fwd || push_flags.rev);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
      run <= '0;
      position <= '0;
    end else if (accept) begin
      window <= window_next;
      run <= run_next;
      position <= position_next;
    end
  end

endmodule

/* src/cns_queue.sv */
module cns_queue #(
  parameter int WIDTH = 80
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty,
  output logic             full
);
  import cns_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty = (count == '0);
  assign full = (count == CNT_FULL);
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* src/cns_back.sv */
module cns_back #(
  parameter int GUIDE_LEN = 23
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [2*GUIDE_LEN-1:0]          head_window,
  input  logic [cns_pkg::START_W-1:0]     head_start,
  input  cns_pkg::match_t                 head_flags,
  input  logic                            empty,
  output logic                            pop,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic [cns_pkg::GUIDE_W-1:0]     guide_code,
  output logic [cns_pkg::START_W-1:0]     start_pos,
  output logic                            strand,
  output logic                            last
);
  import cns_pkg::*;

  localparam int WIN_W = 2 * GUIDE_LEN;

  logic [WIN_W-1:0] rev_window;
  logic             rev_phase;
  logic             load;
  logic             emit_fwd;

  for (genvar i = 0; i < GUIDE_LEN; i++) begin : g_rc
    assign rev_window[2*i+1 -: 2] = ~head_window[2*(GUIDE_LEN-1-i)+1 -: 2];
  end

  assign load = !result_valid || result_ready;
  assign emit_fwd = head_flags.fwd && !rev_phase;
  assign pop = load && !empty && !(emit_fwd && head_flags.rev);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      rev_phase <= 1'b0;
    end else if (load) begin
      result_valid <= !empty;
      if (!empty) begin
        rev_phase <= emit_fwd && head_flags.rev;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      start_pos <= head_start;
      if (emit_fwd) begin
        guide_code <= GUIDE_W'(head_window);
        strand <= 1'b0;
        last <= !head_flags.rev;
      end else begin
        guide_code <= GUIDE_W'(rev_window);
        strand <= 1'b1;
        last <= 1'b1;
      end
    end
  end

endmodule

/* src/cas9_ngg_site_scanner.sv */
// path: a matching base passes the four-entry match queue, then the output register
// throughput: one base per cycle unless the match queue is full; a window with both
// forward and reverse hits gives two results, covered by the match queue
// reset: synchronous rst clears window, run count, position, queue and output valid
module cas9_ngg_site_scanner #(
  parameter int GUIDE_LEN = 23,
  parameter int POS_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           base_valid,
  output logic                           base_ready,
  input  logic [7:0]                     base_char,
  input  logic                           seq_start,
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic [cns_pkg::GUIDE_W-1:0]    guide_code,
  output logic [cns_pkg::START_W-1:0]    start_pos,
  output logic                           strand,
  output logic                           last
);
  import cns_pkg::*;

  localparam int WIN_W = 2 * GUIDE_LEN;
  localparam int ENTRY_W = WIN_W + START_W + 2;

  logic               push, pop, q_full, q_empty;
  logic [WIN_W-1:0]   push_window;
  logic [START_W-1:0] push_start;
  match_t             push_flags;
  logic [ENTRY_W-1:0] head;

  cns_front #(
    .GUIDE_LEN(GUIDE_LEN),
    .POS_WIDTH(POS_WIDTH)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .base_valid(base_valid),
    .base_ready(base_ready),
    .base_char(base_char),
    .seq_start(seq_start),
    .queue_full(q_full),
    .push(push),
    .push_window(push_window),
    .push_start(push_start),
    .push_flags(push_flags)
  );

  cns_queue #(
    .WIDTH(ENTRY_W)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data({push_window, push_start, push_flags}),
    .pop(pop),
    .head(head),
    .empty(q_empty),
    .full(q_full)
  );

  cns_back #(
    .GUIDE_LEN(GUIDE_LEN)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .head_window(head[ENTRY_W-1 -: WIN_W]),
    .head_start(head[START_W+1:2]),
    .head_flags(match_t'(head[1:0])),
    .empty(q_empty),
    .pop(pop),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .guide_code(guide_code),
    .start_pos(start_pos),
    .strand(strand),
    .last(last)
  );

endmodule

/* verif/tb.sv */
module tb;
  import cns_pkg::*;

  localparam int SITE_LEN = GUIDE_W / 2;
  localparam logic FWD_STRAND = 1'b0;
  localparam logic REV_STRAND = 1'b1;
  localparam int RANDOM_BASES = 1900;
  localparam int CYCLE_LIMIT = 1_500_000;

  logic                 clk;
  logic                 rst;
  logic                 base_valid;
  logic                 base_ready;
  logic [7:0]           base_char;
  logic                 seq_start;
  logic                 result_valid;
  logic                 result_ready;
  logic [GUIDE_W-1:0]   guide_code;
  logic [START_W-1:0]   start_pos;
  logic                 strand;
  logic                 last;

  bit                   calm;
  int unsigned          cycles;

  class pam_site_board;
    typedef struct packed {
      logic [GUIDE_W-1:0] guide;
      logic [START_W-1:0] site_pos;
      logic               strand;
      logic               last;
    } site_t;

    logic [GUIDE_W-1:0] window = '0;
    int unsigned        run = 0;
    logic [START_W-1:0] next_pos = '0;
    site_t              due_sites[$];
    int                 miss_count = 0;

    task flag(string what);
      $display("mismatch: %s", what);
      miss_count++;
    endtask

    function logic [GUIDE_W-1:0] flip_strand(logic [GUIDE_W-1:0] w);
      logic [GUIDE_W-1:0] comp;
      logic [GUIDE_W-1:0] r;
      comp = ~w;
      r = '0;
      for (int i = 0; i < SITE_LEN; i++) r[2*(SITE_LEN-1-i) +: 2] = comp[2*i +: 2];
      return r;
    endfunction

    // one accepted base transaction, queues the sites it completes
    function void take_base(logic [7:0] ch, logic first);
      logic [1:0]         code;
      logic [START_W-1:0] here;
      logic [START_W-1:0] site_pos;
      bit                 is_base;
      bit                 fwd;
      bit                 rev;
      if (first) begin
        window = '0;
        run = 0;
        next_pos = '0;
      end
      here = next_pos;
      if (next_pos != '1) next_pos = next_pos + 1'b1;
      is_base = 1'b1;
      code = CODE_A;
      case (ch & CASE_FOLD_MASK)
        CHAR_A: code = CODE_A;
        CHAR_C: code = CODE_C;
        CHAR_G: code = CODE_G;
        CHAR_T: code = CODE_T;
        default: is_base = 1'b0;
      endcase
      if (!is_base) begin
        window = '0;
        run = 0;
        return;
      end
      window = {window[GUIDE_W-3:0], code};
      if (run < SITE_LEN) run++;
      if (run < SITE_LEN) return;
      site_pos = here - START_W'(SITE_LEN - 1);
      fwd = (window[3:0] == PAM_GG);
      rev = (window[GUIDE_W-1 -: 4] == PAM_CC);
      if (fwd)
        due_sites.insert(due_sites.size(), site_t'{window, site_pos, FWD_STRAND, !rev});
      if (rev)
        due_sites.insert(due_sites.size(),
                         site_t'{flip_strand(window), site_pos, REV_STRAND, 1'b1});
    endfunction

    task check_site(logic [GUIDE_W-1:0] g, logic [START_W-1:0] p, logic s, logic l);
      site_t want;
      if (due_sites.size() == 0) begin
        flag($sformatf("unexpected site guide %h pos %0d strand %0b", g, p, s));
        return;
      end
      want = due_sites.pop_front();
      if (g !== want.guide) flag($sformatf("guide got %h want %h", g, want.guide));
      if (p !== want.site_pos) flag($sformatf("start got %0d want %0d", p, want.site_pos));
      if (s !== want.strand) flag($sformatf("strand got %b want %b", s, want.strand));
      if (l !== want.last) flag($sformatf("last got %b want %b", l, want.last));
    endtask
  endclass

  pam_site_board board = new;

  cas9_ngg_site_scanner u_dut (
    .clk          (clk),
    .rst          (rst),
    .base_valid   (base_valid),
    .base_ready   (base_ready),
    .base_char    (base_char),
    .seq_start    (seq_start),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .guide_code   (guide_code),
    .start_pos    (start_pos),
    .strand       (strand),
    .last         (last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // mostly bases, skewed toward c and g so pam sites show up often
  function automatic logic [7:0] pick_char();
    logic [7:0] ch;
    int         r;
    r = $urandom_range(0, 99);
    if (r < 3) return 8'($urandom_range(0, 255));
    if (r < 38) ch = CHAR_G;
    else if (r < 73) ch = CHAR_C;
    else if (r < 86) ch = CHAR_A;
    else ch = CHAR_T;
    if ($urandom_range(0, 1)) ch = ch | ~CASE_FOLD_MASK;
    return ch;
  endfunction

  task automatic send_base(input logic [7:0] ch, input logic first);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      base_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    base_valid = 1'b1;
    base_char = ch;
    seq_start = first;
    do @(posedge clk); while (!base_ready);
    board.take_base(ch, first);
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready)
      board.check_site(guide_code, start_pos, strand, last);
  end

  initial begin
    int hold;
    hold = 0;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        result_ready = 1'b0;
        hold--;
      end else begin
        result_ready = 1'b1;
        if ($urandom_range(0, 2) == 0) hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    string mid;
    mid = "ATGCAtgcaTGCATgcatG";
    calm = 1'b0;
    cycles = 0;
    rst = 1'b1;
    base_valid = 1'b0;
    base_char = 8'h00;
    seq_start = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // window from reset that starts cc and ends gg: forward then reverse site
    send_base(CHAR_C, 1'b0);
    send_base(CHAR_C | ~CASE_FOLD_MASK, 1'b0);
    for (int i = 0; i < mid.len(); i++) send_base(mid[i], 1'b0);
    send_base(CHAR_G | ~CASE_FOLD_MASK, 1'b0);
    send_base(CHAR_G, 1'b0);
    send_base(CHAR_G, 1'b0);
    // broken run, extremes of the character field, new sequence
    send_base(8'h00, 1'b0);
    send_base(8'hFF, 1'b0);
    send_base(CHAR_T, 1'b1);
    send_base(CHAR_T | ~CASE_FOLD_MASK, 1'b0);

    for (int n = 0; n < RANDOM_BASES; n++) begin
      if (n % 120 == 0) calm = ($urandom_range(0, 3) == 0);
      send_base(pick_char(), $urandom_range(0, 99) == 0);
    end

    @(negedge clk);
    base_valid = 1'b0;
    calm = 1'b0;
    while (board.due_sites.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.miss_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
